FILE: src/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg
// shared types, opcode masks and the 0x10 group lookup for the tiler
// command decoder
// ----------------------------------------------------------------------------
package tcd_pkg;

  typedef enum logic [4:0] {
    KindEmpty        = 5'd0,
    KindDrawArrays   = 5'd1,
    KindDrawElements = 5'd2,
    KindIndexedDest  = 5'd3,
    KindIndices      = 5'd4,
    KindIndexedPsize = 5'd5,
    KindViewBottom   = 5'd6,
    KindViewTop      = 5'd7,
    KindViewLeft     = 5'd8,
    KindViewRight    = 5'd9,
    KindTiledDims    = 5'd10,
    KindUnknownOne   = 5'd11,
    KindPrimSetup    = 5'd12,
    KindPrimInit     = 5'd13,
    KindBlockStep    = 5'd14,
    KindLowPrimSize  = 5'd15,
    KindDepthNear    = 5'd16,
    KindDepthFar     = 5'd17,
    KindArrayAddr    = 5'd18,
    KindBlockStride  = 5'd19,
    KindEnd          = 5'd20,
    KindSemBegin     = 5'd21,
    KindSemEnd       = 5'd22,
    KindSemUnknown   = 5'd23,
    KindScissors     = 5'd24,
    KindVertexArray  = 5'd25,
    KindContinue     = 5'd26,
    KindUnknown      = 5'd27
  } kind_e;

  localparam logic [31:0] DrawMask     = 32'hffe00000;
  localparam logic [31:0] DrawElemCode = 32'h00200000;
  localparam logic [31:0] Group10Mask  = 32'hff000ff0;
  localparam logic [31:0] Group10Code  = 32'h10000100;
  localparam logic [31:0] ByteMask     = 32'hff000000;
  localparam logic [31:0] ArrayCode    = 32'h28000000;
  localparam logic [31:0] EndWord      = 32'h50000000;
  localparam logic [31:0] SemBeginWord = 32'h00010002;
  localparam logic [31:0] SemEndWord   = 32'h00010001;
  localparam logic [31:0] PrimInitWord = 32'h00000200;

  localparam logic [3:0] TopStride  = 4'h3;
  localparam logic [3:0] TopSem     = 4'h6;
  localparam logic [3:0] TopScissor = 4'h7;
  localparam logic [3:0] TopVertex  = 4'h8;
  localparam logic [3:0] TopCont    = 4'hf;

  localparam logic [3:0] PrimPoints = 4'h0;
  localparam logic [3:0] PrimLines  = 4'h3;
  localparam logic [3:0] PrimTris   = 4'h2;

  // payload handed from the classify stage to the extract stage
  typedef struct packed {
    kind_e       kind;
    logic [31:0] lo;
    logic [31:0] hi;
  } cls_word_t;

  function automatic kind_e group10_kind(input logic [3:0] code);
    kind_e k;
    case (code)
      4'h0:    k = KindIndexedDest;
      4'h1:    k = KindIndices;
      4'h2:    k = KindIndexedPsize;
      4'h5:    k = KindViewBottom;
      4'h6:    k = KindViewTop;
      4'h7:    k = KindViewLeft;
      4'h8:    k = KindViewRight;
      4'h9:    k = KindTiledDims;
      4'ha:    k = KindUnknownOne;
      4'hb:    k = KindPrimSetup;
      4'hc:    k = KindBlockStep;
      4'hd:    k = KindLowPrimSize;
      4'he:    k = KindDepthNear;
      4'hf:    k = KindDepthFar;
      default: k = KindUnknown;
    endcase
    return k;
  endfunction

endpackage

FILE: src/tcd_classify.sv
// ----------------------------------------------------------------------------
// tcd_classify
// priority chain of mask-and-compare tests that picks the command kind,
// followed by one pipeline register
// ----------------------------------------------------------------------------
module tcd_classify import tcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] lo_i,
  input  logic [31:0] hi_i,
  output logic        valid_o,
  input  logic        ready_i,
  output cls_word_t   word_o
);

  logic      valid_q;
  cls_word_t word_q;
  cls_word_t word_d;
  kind_e     kind;
  kind_e     g10;

  assign g10 = group10_kind(hi_i[3:0]);

  always_comb begin
    kind = KindUnknown;
    if ((hi_i & DrawMask) == '0 || (hi_i & DrawMask) == DrawElemCode) begin
      if (lo_i == '0 && hi_i == '0) begin
        kind = KindEmpty;
      end else if (hi_i[21] == 1'b0) begin
        kind = KindDrawArrays;
      end else begin
        kind = KindDrawElements;
      end
    end else if ((hi_i & Group10Mask) == Group10Code && g10 != KindUnknown) begin
      // primitive setup with the init operand has a kind of its own
      if (g10 == KindPrimSetup && lo_i == PrimInitWord) begin
        kind = KindPrimInit;
      end else begin
        kind = g10;
      end
    end else if ((hi_i & ByteMask) == ArrayCode) begin
      kind = KindArrayAddr;
    end else if (hi_i[31:28] == TopStride) begin
      kind = KindBlockStride;
    end else if (hi_i == EndWord) begin
      kind = KindEnd;
    end else if (hi_i[31:28] == TopSem) begin
      if (lo_i == SemBeginWord) begin
        kind = KindSemBegin;
      end else if (lo_i == SemEndWord) begin
        kind = KindSemEnd;
      end else begin
        kind = KindSemUnknown;
      end
    end else if (hi_i[31:28] == TopScissor) begin
      kind = KindScissors;
    end else if (hi_i[31:28] == TopVertex) begin
      kind = KindVertexArray;
    end else if (hi_i[31:28] == TopCont) begin
      kind = KindContinue;
    end
  end

  assign word_d.kind = kind;
  assign word_d.lo   = lo_i;
  assign word_d.hi   = hi_i;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

FILE: src/tcd_extract.sv
// ----------------------------------------------------------------------------
// tcd_extract
// pulls the kind-dependent fields out of the command pair and holds them
// in the output register
// ----------------------------------------------------------------------------
module tcd_extract import tcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  cls_word_t   word_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [4:0]  kind_o,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [15:0] c_o,
  output logic [15:0] d_o
);

  logic        valid_q;
  logic [4:0]  kind_q;
  logic [31:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [15:0] c_q, c_d;
  logic [15:0] d_q, d_d;
  logic [31:0] lo, hi;
  logic [1:0]  prim;

  assign lo = word_i.lo;
  assign hi = word_i.hi;

  always_comb begin
    case (lo[15:12])
      PrimPoints: prim = 2'd0;
      PrimLines:  prim = 2'd1;
      PrimTris:   prim = 2'd2;
      default:    prim = 2'd3;
    endcase
  end

  always_comb begin
    a_d = '0;
    b_d = '0;
    c_d = '0;
    d_d = '0;
    case (word_i.kind)
      KindDrawArrays, KindDrawElements: begin
        a_d = {16'd0, hi[7:0], lo[31:24]};
        b_d = {8'd0, lo[23:0]};
        c_d = {11'd0, hi[20:16]};
      end
      KindIndexedDest, KindIndices, KindIndexedPsize, KindViewBottom, KindViewTop,
      KindViewLeft, KindViewRight, KindUnknownOne, KindLowPrimSize, KindDepthNear,
      KindDepthFar, KindContinue: begin
        a_d = lo;
      end
      KindTiledDims: begin
        a_d = {24'd0, lo[31:24]} + 32'd1;
        b_d = {16'd0, lo[23:8]} + 32'd1;
      end
      KindPrimSetup: begin
        a_d = {30'd0, prim};
        b_d = {28'd0, lo[19:16]};
        c_d = {12'd0, lo[12:9]};
      end
      KindBlockStep: begin
        a_d = {28'd0, lo[31:28]};
        b_d = {20'd0, lo[27:16]};
        c_d = lo[15:0];
      end
      KindArrayAddr: begin
        a_d = lo;
        b_d = {8'd0, hi[23:0]} + 32'd1;
      end
      KindBlockStride: begin
        a_d = {24'd0, lo[7:0]};
      end
      KindScissors: begin
        a_d = {17'd0, hi[12:0], lo[31:30]};
        b_d = {13'd0, hi[31:13]} + 32'd1;
        c_d = {2'd0, lo[13:0]};
        d_d = {1'b0, hi[29:15]} + 16'd1;
      end
      KindVertexArray: begin
        a_d = lo;
        b_d = {hi[27:0], 4'd0};
      end
      default: begin
        a_d = '0;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      kind_q <= word_i.kind;
      a_q    <= a_d;
      b_q    <= b_d;
      c_q    <= c_d;
      d_q    <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign c_o     = c_q;
  assign d_o     = d_q;

endmodule

FILE: src/tiler_command_decoder_top.sv
// ----------------------------------------------------------------------------
// tiler_command_decoder_top
// decodes one 64-bit polygon-list-builder command per word into a command
// kind and four generic fields
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o with word_low_i and word_high_i;
//   a word is taken at a clock edge where in_valid_i is high and in_stall_o
//   is low
//   output channel: out_valid_o / out_stall_i with command_kind_o and
//   field_a_o .. field_d_o; a word leaves where out_valid_o is high and
//   out_stall_i is low
//   path: a taken word passes the input register, the kind decode register
//   and the field extract register before out_valid_o rises; a stall can
//   hold it in any of them
//   throughput: one word per cycle while out_stall_i is low (three-stage
//   pipeline); each stage reloads in the same cycle its content moves on
//   stall: a full stage holds while the stage after it is held; empty
//   stages keep filling, so in_stall_o rises only once all three stages
//   are full and out_stall_i is high
//   reset: rst_ni clears the valid bits of all stages; the payload
//   registers are not reset, and nothing needs configuring
// ----------------------------------------------------------------------------
module tiler_command_decoder_top import tcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] word_low_i,
  input  logic [31:0] word_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  command_kind_o,
  output logic [31:0] field_a_o,
  output logic [31:0] field_b_o,
  output logic [15:0] field_c_o,
  output logic [15:0] field_d_o
);

  // stage 0: input register
  logic        s0_valid_q;
  logic [31:0] s0_lo_q;
  logic [31:0] s0_hi_q;
  logic        s0_ready;

  // stage 1 / stage 2 handshakes
  logic        s1_ready;
  logic        s1_valid;
  cls_word_t   s1_word;
  logic        s2_ready;

  assign s0_ready   = !s0_valid_q || s1_ready;
  assign in_stall_o = !s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_q <= in_valid_i;
    end
  end

  // payload only loads on an accepted word
  always_ff @(posedge clk_i) begin
    if (s0_ready && in_valid_i) begin
      s0_lo_q <= word_low_i;
      s0_hi_q <= word_high_i;
    end
  end

  // stage 1: priority chain picks the kind
  tcd_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_valid_q),
    .ready_o (s1_ready),
    .lo_i    (s0_lo_q),
    .hi_i    (s0_hi_q),
    .valid_o (s1_valid),
    .ready_i (s2_ready),
    .word_o  (s1_word)
  );

  // stage 2: field extraction into the output register
  tcd_extract u_extract (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .word_i  (s1_word),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .kind_o  (command_kind_o),
    .a_o     (field_a_o),
    .b_o     (field_b_o),
    .c_o     (field_c_o),
    .d_o     (field_d_o)
  );

endmodule

FILE: tb/tiler_command_decoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tiler_command_decoder_top_tb
// self-checking bench for the tiler command decoder: a directed table of
// command words with no idle or stall, then randomized command streams
// under random idle and stall, all results scoreboarded against a
// behavioral decoder or, for typed directed rows, their own expectation
module tiler_command_decoder_top_tb;
  import tcd_pkg::*;

  // run control
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned ResetCycles    = 10;
  localparam int unsigned RandomPerPhase = 140;
  localparam int unsigned PhaseCount     = 5;
  localparam int unsigned HoldCycles     = 300;
  // three pipeline stages plus some slack
  localparam int unsigned DrainCycles    = 8;

  // prim codes reported in field_a of a primitive setup
  localparam logic [31:0] PrimCodePoints = 32'd0;
  localparam logic [31:0] PrimCodeLines  = 32'd1;
  localparam logic [31:0] PrimCodeTris   = 32'd2;
  localparam logic [31:0] PrimCodeOther  = 32'd3;

  // one decoded command as it leaves the block
  typedef struct packed {
    kind_e       kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [15:0] c;
    logic [15:0] d;
  } cmd_result_t;

  // one row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic        typed;
    cmd_result_t exp;
  } stim_row_t;

  // shapes of random command words
  typedef enum int unsigned {
    CatDrawArrays,
    CatDrawElements,
    CatGroup10,
    CatArrayAddr,
    CatStride,
    CatEnd,
    CatSemaphore,
    CatScissors,
    CatVertex,
    CatContinue,
    CatEmpty,
    CatFree,
    CatCount
  } word_cat_e;

  // ---------------------------------------------------------------------------
  // clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [31:0] word_low  = '0;
  logic [31:0] word_high = '0;
  logic        out_stall = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [4:0]  command_kind_o;
  logic [31:0] field_a_o;
  logic [31:0] field_b_o;
  logic [15:0] field_c_o;
  logic [15:0] field_d_o;

  always #2 clk = ~clk;

  tiler_command_decoder_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .word_low_i     (word_low),
    .word_high_i    (word_high),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .command_kind_o (command_kind_o),
    .field_a_o      (field_a_o),
    .field_b_o      (field_b_o),
    .field_c_o      (field_c_o),
    .field_d_o      (field_d_o)
  );

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  // kinds of the sixteen low opcode codes of the 0x10 group
  kind_e group10_table [16] = '{
    KindIndexedDest, KindIndices,    KindIndexedPsize, KindUnknown,
    KindUnknown,     KindViewBottom, KindViewTop,      KindViewLeft,
    KindViewRight,   KindTiledDims,  KindUnknownOne,   KindPrimSetup,
    KindBlockStep,   KindLowPrimSize, KindDepthNear,   KindDepthFar
  };

  // idle and stall rates per random phase, in percent
  int unsigned send_idle_by_phase  [PhaseCount] = '{0, 52, 0, 37, 0};
  int unsigned recv_stall_by_phase [PhaseCount] = '{0, 0, 52, 37, 0};

  cmd_result_t pending_results [$];
  stim_row_t   directed_rows [$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;

  // ---------------------------------------------------------------------------
  // behavioral decoder
  // ---------------------------------------------------------------------------
  function automatic cmd_result_t decode_command(input logic [31:0] lo,
                                                 input logic [31:0] hi);
    cmd_result_t r;
    kind_e       g;
    r      = '0;
    r.kind = KindUnknown;
    g      = group10_table[hi[3:0]];
    if ((hi & DrawMask) == '0 || (hi & DrawMask) == DrawElemCode) begin
      // draw family, all-zero pair is the empty command
      if (lo == '0 && hi == '0) begin
        r.kind = KindEmpty;
      end else begin
        r.kind = ((hi & DrawMask) == '0) ? KindDrawArrays : KindDrawElements;
        r.a    = {16'h0, hi[7:0], lo[31:24]};
        r.b    = {8'h0, lo[23:0]};
        r.c    = {11'h0, hi[20:16]};
      end
    end else if ((hi & Group10Mask) == Group10Code && g != KindUnknown) begin
      r.kind = g;
      case (g)
        KindTiledDims: begin
          r.a = {24'h0, lo[31:24]} + 32'd1;
          r.b = {16'h0, lo[23:8]} + 32'd1;
        end
        KindPrimSetup: begin
          if (lo == PrimInitWord) begin
            r.kind = KindPrimInit;
          end else begin
            case (lo[15:12])
              PrimPoints: r.a = PrimCodePoints;
              PrimLines:  r.a = PrimCodeLines;
              PrimTris:   r.a = PrimCodeTris;
              default:    r.a = PrimCodeOther;
            endcase
            r.b = {28'h0, lo[19:16]};
            r.c = {12'h0, lo[12:9]};
          end
        end
        KindBlockStep: begin
          r.a = {28'h0, lo[31:28]};
          r.b = {20'h0, lo[27:16]};
          r.c = lo[15:0];
        end
        default: begin
          r.a = lo;
        end
      endcase
    end else if ((hi & ByteMask) == ArrayCode) begin
      r.kind = KindArrayAddr;
      r.a    = lo;
      r.b    = {8'h0, hi[23:0]} + 32'd1;
    end else if (hi[31:28] == TopStride) begin
      r.kind = KindBlockStride;
      r.a    = {24'h0, lo[7:0]};
    end else if (hi == EndWord) begin
      r.kind = KindEnd;
    end else if (hi[31:28] == TopSem) begin
      if (lo == SemBeginWord) begin
        r.kind = KindSemBegin;
      end else if (lo == SemEndWord) begin
        r.kind = KindSemEnd;
      end else begin
        r.kind = KindSemUnknown;
      end
    end else if (hi[31:28] == TopScissor) begin
      r.kind = KindScissors;
      r.a    = {17'h0, hi[12:0], lo[31:30]};
      r.b    = {13'h0, hi[31:13]} + 32'd1;
      r.c    = {2'h0, lo[13:0]};
      r.d    = {1'b0, hi[29:15]} + 16'd1;
    end else if (hi[31:28] == TopVertex) begin
      r.kind = KindVertexArray;
      r.a    = lo;
      r.b    = {hi[27:0], 4'h0};
    end else if (hi[31:28] == TopCont) begin
      r.kind = KindContinue;
      r.a    = lo;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  task automatic add_row(input logic [31:0] lo, input logic [31:0] hi,
                         input logic typed, input kind_e k,
                         input logic [31:0] a, input logic [31:0] b,
                         input logic [15:0] c, input logic [15:0] d);
    stim_row_t row;
    row.lo       = lo;
    row.hi       = hi;
    row.typed    = typed;
    row.exp.kind = k;
    row.exp.a    = a;
    row.exp.b    = b;
    row.exp.c    = c;
    row.exp.d    = d;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed_rows();
    // draw family: empty pair and field extremes
    add_row(32'h00000000, 32'h00000000, 1, KindEmpty, 0, 0, 0, 0);
    add_row(32'h00000001, 32'h00000000, 1, KindDrawArrays, 0, 1, 0, 0);
    add_row(32'hffffffff, 32'h001fffff, 1, KindDrawArrays,
            32'hffff, 32'hffffff, 16'h1f, 0);
    add_row(32'hffffffff, 32'h003fffff, 1, KindDrawElements,
            32'hffff, 32'hffffff, 16'h1f, 0);
    // 0x10 group, every low code including the two holes
    add_row(32'h12345678, 32'h10000100, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'hffffffff, 32'h10fff101, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'h80000001, 32'h10123102, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'hffffffff, 32'h10000103, 1, KindUnknown, 0, 0, 0, 0);
    add_row(32'hffffffff, 32'h10abc104, 1, KindUnknown, 0, 0, 0, 0);
    add_row(32'h3f800000, 32'h10000105, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'h00000000, 32'h10000106, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'hbf800000, 32'h10000107, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'h44800000, 32'h10000108, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'hffffffff, 32'h10000109, 1, KindTiledDims,
            32'h100, 32'h10000, 0, 0);
    add_row(32'h00000000, 32'h1000010a, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'h0003f3ff, 32'h1000010b, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'h00000200, 32'h1000010b, 1, KindPrimInit, 0, 0, 0, 0);
    add_row(32'hffffffff, 32'h1000010c, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'h3f000000, 32'h1000010d, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'h00000000, 32'h1000010e, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'h3f800000, 32'h1000010f, 0, KindUnknown, 0, 0, 0, 0);
    // the remaining opcode families
    add_row(32'hdeadbeef, 32'h28ffffff, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'hffffffff, 32'h3fffffff, 0, KindUnknown, 0, 0, 0, 0);
    // end needs the exact high word, with bit 0 set it is an unknown command
    add_row(32'hffffffff, 32'h50000000, 1, KindEnd, 0, 0, 0, 0);
    add_row(32'h00000000, 32'h50000001, 1, KindUnknown, 0, 0, 0, 0);
    add_row(32'h00010002, 32'h60000000, 1, KindSemBegin, 0, 0, 0, 0);
    add_row(32'h00010001, 32'h6fffffff, 1, KindSemEnd, 0, 0, 0, 0);
    add_row(32'h00000000, 32'h6fffffff, 1, KindSemUnknown, 0, 0, 0, 0);
    add_row(32'hffffffff, 32'h7fffffff, 1, KindScissors,
            32'h7fff, 32'h40000, 16'h3fff, 16'h8000);
    add_row(32'hffffffff, 32'h8fffffff, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'h00000000, 32'hf0000000, 0, KindUnknown, 0, 0, 0, 0);
    add_row(32'hffffffff, 32'h40000000, 1, KindUnknown, 0, 0, 0, 0);
  endtask

  // ---------------------------------------------------------------------------
  // random command words, mostly well-formed with random content
  // ---------------------------------------------------------------------------
  task automatic make_random_word(output logic [31:0] lo, output logic [31:0] hi);
    word_cat_e cat;
    lo  = $urandom();
    hi  = $urandom();
    cat = word_cat_e'($urandom_range(0, CatCount - 1));
    case (cat)
      CatDrawArrays:   hi = hi & ~DrawMask;
      CatDrawElements: hi = (hi & ~DrawMask) | DrawElemCode;
      CatGroup10: begin
        hi = (hi & ~Group10Mask) | Group10Code;
        // primitive init now and then
        if (group10_table[hi[3:0]] == KindPrimSetup && $urandom_range(0, 3) == 0) begin
          lo = PrimInitWord;
        end
      end
      CatArrayAddr: hi = (hi & ~ByteMask) | ArrayCode;
      CatStride:    hi[31:28] = TopStride;
      CatEnd: begin
        // exact end word, or one bit off it
        if ($urandom_range(0, 3) == 0) begin
          hi = EndWord ^ (32'h1 << $urandom_range(0, 31));
        end else begin
          hi = EndWord;
        end
      end
      CatSemaphore: begin
        hi[31:28] = TopSem;
        if ($urandom_range(0, 2) == 0) begin
          lo = SemBeginWord;
        end else if ($urandom_range(0, 1) == 0) begin
          lo = SemEndWord;
        end
      end
      CatScissors: hi[31:28] = TopScissor;
      CatVertex:   hi[31:28] = TopVertex;
      CatContinue: hi[31:28] = TopCont;
      CatEmpty: begin
        lo = '0;
        hi = '0;
      end
      default: begin
        // fully random noise word
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // sender: optional idle gap, then hold the word until it is taken
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [31:0] lo, input logic [31:0] hi,
                           input cmd_result_t exp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    word_low  <= lo;
    word_high <= hi;
    @(posedge clk);
    // pre-edge values are seen here, so this is the accepting edge
    while (in_stall_o) @(posedge clk);
    pending_results.push_back(exp);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall, plus one long hold-off counted here
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_left  = HoldCycles;
        hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // scoreboard
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s expected %0h actual %0h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    cmd_result_t exp;
    if (rst_n && out_valid_o && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("output word with nothing expected, kind %0d", command_kind_o);
        error_count++;
      end else begin
        exp = pending_results.pop_front();
        check_field("command_kind", {27'h0, exp.kind}, {27'h0, command_kind_o});
        check_field("field_a", exp.a, field_a_o);
        check_field("field_b", exp.b, field_b_o);
        check_field("field_c", {16'h0, exp.c}, {16'h0, field_c_o});
        check_field("field_d", {16'h0, exp.d}, {16'h0, field_d_o});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t   row;
    logic [31:0] lo;
    logic [31:0] hi;
    build_directed_rows();
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_word(row.lo, row.hi, row.typed ? row.exp : decode_command(row.lo, row.hi));
    end

    // random phases; the last one starts with the long receiver hold-off
    for (int phase = 0; phase < PhaseCount; phase++) begin
      send_idle_pct  = send_idle_by_phase[phase];
      recv_stall_pct = recv_stall_by_phase[phase];
      if (phase == PhaseCount - 1) hold_req = 1'b1;
      repeat (RandomPerPhase) begin
        make_random_word(lo, hi);
        send_word(lo, hi, decode_command(lo, hi));
      end
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    // drain, then wait out DrainCycles to catch stray words
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
